FILE: rtl/amon_pkg.sv
// Shared types, constants and slot tables for the ADC telemetry monitor.
`default_nettype none

package amon_pkg;

    localparam int ADC_BITS    = 10;
    localparam int SLOT_W      = 4;
    localparam int SCALE_W     = 10;
    localparam int DIV_W       = 7;
    localparam int PROD_W      = 20;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 20;
    localparam int MV_W        = 16;
    localparam int TEMP_W      = 14;
    localparam int Q100_W      = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int S_DATA_W    = 16;
    localparam int S_USER_W    = 8;
    localparam int M_DATA_W    = 72;
    localparam int M_USER_W    = 8;

    // x / 100 == (x * RECIP100) >> RECIP100_SHIFT for every 16-bit x
    localparam int RECIP100_W     = 17;
    localparam int RECIP100_SHIFT = 23;
    localparam logic [RECIP100_W-1:0] RECIP100 = 17'd83887;

    localparam logic [11:0] MV_FULL_SCALE = 12'd3300;
    localparam int          MV_SHIFT      = 10;

    localparam logic [SLOT_W-1:0] SLOT_LED1_V = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_LED2_V = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_SUPPLY = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_AUX    = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_LED2_I = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_LED1_I = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_THERM  = 4'd9;

    localparam logic [1:0] EV_NONE        = 2'd0;
    localparam logic [1:0] EV_PWR_LOST    = 2'd1;
    localparam logic [1:0] EV_PWR_RESUMED = 2'd2;
    localparam logic [1:0] EV_RISE        = 2'd1;
    localparam logic [1:0] EV_FALL        = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LED1_CV       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LED2_CV       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_LOST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_RESUME = 3'd5;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_RECIP,
        OP_CORR,
        OP_SCALE,
        OP_UPDATE,
        OP_DIV100,
        OP_POWER,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic [MV_W-1:0] sensor_high_mv;
        logic [MV_W-1:0] sensor_low_mv;
        logic            led1_cv_mode;
        logic            led2_cv_mode;
        logic [MV_W-1:0] supply_lost_mv;
        logic [MV_W-1:0] supply_resume_mv;
    } cfg_t;

    // Unused slots get a zero scale so they come out as zero millivolts.
    function automatic logic [SCALE_W-1:0] slot_scale(input logic [SLOT_W-1:0] slot);
        logic [SCALE_W-1:0] s;
        unique case (slot)
            4'd0, 4'd3, 4'd7: s = 10'd212;
            4'd1, 4'd2:       s = 10'd210;
            4'd4:             s = 10'd122;
            4'd5, 4'd6:       s = 10'd30;
            4'd8:             s = 10'd542;
            4'd9:             s = 10'd1;
            default:          s = 10'd0;
        endcase
        return s;
    endfunction

    function automatic logic [DIV_W-1:0] slot_div(input logic [SLOT_W-1:0] slot);
        logic [DIV_W-1:0] d;
        unique case (slot)
            4'd0, 4'd3, 4'd7: d = 7'd12;
            4'd1, 4'd2:       d = 7'd10;
            4'd4:             d = 7'd22;
            4'd5, 4'd6:       d = 7'd11;
            4'd8:             d = 7'd67;
            default:          d = 7'd1;
        endcase
        return d;
    endfunction

    // floor(2^20 / divisor); the estimate is at most one below the true quotient
    function automatic logic [RECIP_W-1:0] slot_recip(input logic [SLOT_W-1:0] slot);
        logic [RECIP_W-1:0] m;
        unique case (slot)
            4'd0, 4'd3, 4'd7: m = 21'd87381;
            4'd1, 4'd2:       m = 21'd104857;
            4'd4:             m = 21'd47662;
            4'd5, 4'd6:       m = 21'd95325;
            4'd8:             m = 21'd15650;
            default:          m = 21'd1048576;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/amon_ctrl.sv
// Sequencer for the ADC telemetry monitor: steps the datapath and runs both handshakes.
`default_nettype none

module amon_ctrl
    import amon_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output op_t       op
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_CORR,
        ST_SCALE,
        ST_UPDATE,
        ST_DIV100,
        ST_POWER,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        op           = OP_IDLE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = ST_RECIP;
                end
            end
            ST_RECIP: begin
                op         = OP_RECIP;
                state_next = ST_CORR;
            end
            ST_CORR: begin
                op         = OP_CORR;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                op         = OP_SCALE;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                op         = OP_UPDATE;
                state_next = ST_DIV100;
            end
            ST_DIV100: begin
                op         = OP_DIV100;
                state_next = ST_POWER;
            end
            ST_POWER: begin
                op         = OP_POWER;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    op           = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/amon_dp.sv
// Datapath for the ADC telemetry monitor: scaling, hysteresis, temperature and LED power.
`default_nettype none

module amon_dp
    import amon_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire op_t                 op,
    input  wire cfg_t                cfg,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [S_USER_W-1:0] s_tuser,
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic      [M_USER_W-1:0] m_tuser
);

    // working registers of one word
    logic [SLOT_W-1:0]  slot_reg;
    logic [ADC_BITS-1:0] raw_reg;
    logic [PROD_W-1:0]  x_reg;
    logic [PROD_W-1:0]  q0_reg;
    logic [PROD_W-1:0]  q_reg;
    logic [MV_W-1:0]    mv_reg;
    logic [Q100_W-1:0]  qv_reg;
    logic [Q100_W-1:0]  qi_reg;
    logic [1:0]         pev_reg;
    logic [1:0]         sev_reg;

    // state kept across words
    logic               ext_on_reg;
    logic               sensor_on_reg;
    logic [MV_W-1:0]    led_v_reg [2];
    logic [MV_W-1:0]    led_i_reg [2];
    logic [MV_W-1:0]    led_p_reg [2];
    logic [TEMP_W-1:0]  temp_reg;

    // output register
    logic [SLOT_W-1:0]  o_slot_reg;
    logic [MV_W-1:0]    o_mv_reg;
    logic               o_ext_reg;
    logic [1:0]         o_pev_reg;
    logic               o_sensor_reg;
    logic [1:0]         o_sev_reg;
    logic [TEMP_W-1:0]  o_temp_reg;
    logic [MV_W-1:0]    o_p1_reg;
    logic [MV_W-1:0]    o_p2_reg;

    logic [SLOT_W-1:0]          in_slot;
    logic [ADC_BITS-1:0]        in_raw;
    logic [PROD_W-1:0]          x_next;
    logic [PROD_W+RECIP_W-1:0]  recip_prod;
    logic [PROD_W-1:0]          q0_next;
    logic [DIV_W-1:0]           div;
    logic [PROD_W-1:0]          qd;
    logic [PROD_W-1:0]          rem;
    logic [PROD_W-1:0]          q_next;
    logic [31:0]                w;
    logic [MV_W-1:0]            mv_next;
    logic [18:0]                mv5;
    logic [17:0]                mv_half;
    logic [MV_W-1:0]            cur_cv;
    logic [MV_W-1:0]            cur1;
    logic [MV_W-1:0]            cur2;
    logic [TEMP_W:0]            temp_wide;
    logic                       led_sel;
    logic                       led_slot;
    logic [MV_W+RECIP100_W-1:0] v_prod;
    logic [MV_W+RECIP100_W-1:0] i_prod;
    logic [2*Q100_W-1:0]        p_prod;
    logic [MV_W-1:0]            p_sat;

    assign in_slot = s_tuser[SLOT_W-1:0];
    assign in_raw  = s_tdata[ADC_BITS-1:0];

    assign x_next     = PROD_W'(in_raw) * PROD_W'(slot_scale(in_slot));
    assign recip_prod = (PROD_W+RECIP_W)'(x_reg) * (PROD_W+RECIP_W)'(slot_recip(slot_reg));
    assign q0_next    = recip_prod[RECIP_SHIFT +: PROD_W];

    // estimate may be one short: bump it when the remainder reaches the divisor
    assign div    = slot_div(slot_reg);
    assign qd     = q0_reg * PROD_W'(div);
    assign rem    = x_reg - qd;
    assign q_next = (rem >= PROD_W'(div)) ? q0_reg + PROD_W'(1) : q0_reg;

    assign w       = 32'(q_reg) * 32'(MV_FULL_SCALE);
    assign mv_next = (|w[31:MV_SHIFT+MV_W]) ? {MV_W{1'b1}} : w[MV_SHIFT +: MV_W];

    assign mv5     = 19'(mv_reg) * 19'd5;
    assign mv_half = mv5[18:1];
    assign cur_cv  = (|mv_half[17:MV_W]) ? {MV_W{1'b1}} : mv_half[MV_W-1:0];
    assign cur1    = cfg.led1_cv_mode ? cur_cv : mv_reg;
    assign cur2    = cfg.led2_cv_mode ? cur_cv : mv_reg;

    assign temp_wide = (raw_reg < 10'd600)
                     ? (TEMP_W+1)'(4676) - (TEMP_W+1)'(raw_reg) * (TEMP_W+1)'(7)
                     : (TEMP_W+1)'(1649) - (TEMP_W+1)'(raw_reg) * (TEMP_W+1)'(2);

    assign led_sel  = (slot_reg == SLOT_LED2_V) || (slot_reg == SLOT_LED2_I);
    assign led_slot = (slot_reg == SLOT_LED1_V) || (slot_reg == SLOT_LED2_V)
                   || (slot_reg == SLOT_LED1_I) || (slot_reg == SLOT_LED2_I);

    assign v_prod = (MV_W+RECIP100_W)'(led_v_reg[led_sel]) * (MV_W+RECIP100_W)'(RECIP100);
    assign i_prod = (MV_W+RECIP100_W)'(led_i_reg[led_sel]) * (MV_W+RECIP100_W)'(RECIP100);
    assign p_prod = (2*Q100_W)'(qv_reg) * (2*Q100_W)'(qi_reg);
    assign p_sat  = (|p_prod[2*Q100_W-1:MV_W]) ? {MV_W{1'b1}} : p_prod[MV_W-1:0];

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (op)
            OP_LOAD: begin
                slot_reg <= in_slot;
                raw_reg  <= in_raw;
                x_reg    <= x_next;
            end
            OP_RECIP:  q0_reg <= q0_next;
            OP_CORR:   q_reg  <= q_next;
            OP_SCALE:  mv_reg <= mv_next;
            OP_DIV100: begin
                qv_reg <= v_prod[RECIP100_SHIFT +: Q100_W];
                qi_reg <= i_prod[RECIP100_SHIFT +: Q100_W];
            end
            OP_OUT: begin
                o_slot_reg   <= slot_reg;
                o_mv_reg     <= mv_reg;
                o_ext_reg    <= ext_on_reg;
                o_pev_reg    <= pev_reg;
                o_sensor_reg <= sensor_on_reg;
                o_sev_reg    <= sev_reg;
                o_temp_reg   <= temp_reg;
                o_p1_reg     <= led_p_reg[0];
                o_p2_reg     <= led_p_reg[1];
            end
            default: ;
        endcase
    end

    // monitor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_on_reg    <= 1'b0;
            sensor_on_reg <= 1'b0;
            led_v_reg[0]  <= '0;
            led_v_reg[1]  <= '0;
            led_i_reg[0]  <= '0;
            led_i_reg[1]  <= '0;
            led_p_reg[0]  <= '0;
            led_p_reg[1]  <= '0;
            temp_reg      <= '0;
            pev_reg       <= EV_NONE;
            sev_reg       <= EV_NONE;
        end else begin
            if (op == OP_UPDATE) begin
                pev_reg <= EV_NONE;
                sev_reg <= EV_NONE;
                unique case (slot_reg)
                    SLOT_LED1_V: led_v_reg[0] <= mv_reg;
                    SLOT_LED2_V: led_v_reg[1] <= mv_reg;
                    SLOT_LED1_I: led_i_reg[0] <= cur1;
                    SLOT_LED2_I: led_i_reg[1] <= cur2;
                    SLOT_SUPPLY: begin
                        if (mv_reg < cfg.supply_lost_mv && !ext_on_reg) begin
                            ext_on_reg <= 1'b1;
                            pev_reg    <= EV_PWR_LOST;
                        end else if (mv_reg > cfg.supply_resume_mv && ext_on_reg) begin
                            ext_on_reg <= 1'b0;
                            pev_reg    <= EV_PWR_RESUMED;
                        end
                    end
                    SLOT_AUX: begin
                        if (mv_reg > cfg.sensor_high_mv && !sensor_on_reg) begin
                            sensor_on_reg <= 1'b1;
                            sev_reg       <= EV_RISE;
                        end else if (mv_reg < cfg.sensor_low_mv && sensor_on_reg) begin
                            sensor_on_reg <= 1'b0;
                            sev_reg       <= EV_FALL;
                        end
                    end
                    SLOT_THERM: temp_reg <= temp_wide[TEMP_W-1:0];
                    default: ;
                endcase
            end
            if (op == OP_POWER && led_slot) begin
                led_p_reg[led_sel] <= p_sat;
            end
        end
    end

    assign m_tuser = M_USER_W'(o_slot_reg);
    assign m_tdata = {4'b0, o_p2_reg, o_p1_reg, o_temp_reg, o_sev_reg, o_sensor_reg,
                      o_pev_reg, o_ext_reg, o_mv_reg};

endmodule

`default_nettype wire

FILE: rtl/adc_telemetry_monitor.sv
// Top level of the ADC telemetry monitor: configuration registers, sequencer and datapath.
//
//  channel   dir  handshake              content
//  s_*       in   s_tvalid / s_tready    one ADC conversion with its scan slot
//  m_*       out  m_tvalid / m_tready    millivolts, events, temperature, LED power
//  cfg_*     in   cfg_valid / cfg_ready  register index and write data
//
// An item passes from acceptance to the output register in the single sequencer pass:
// product, reciprocal multiply, quotient correction, mV scaling, state update, divide
// by 100 and power multiply. The next item is taken only once the pass is back in idle.
// aresetn is synchronous, active low; it clears the sequencer, monitor state and
// restores register defaults. The output register holds a word while m_tready is low;
// the next item is still accepted and the sequence waits only at its final step.
`default_nettype none

module adc_telemetry_monitor
    import amon_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // raw_sample[9:0], zero pad
    input  wire logic [S_USER_W-1:0]  s_tuser,   // slot_index[3:0], zero pad
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_DATA_W-1:0]  m_tdata,   // millivolts[15:0], ext_power_active[16],
                                                 // power_event[18:17], sensor_active[19],
                                                 // sensor_edge[21:20], temperature_x10[35:22],
                                                 // led1_power[51:36], led2_power[67:52], pad
    output logic      [M_USER_W-1:0]  m_tuser,   // slot_echo[3:0], zero pad
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MV_W-1:0]      cfg_data
);

    cfg_t cfg_reg;
    op_t  op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_high_mv   <= 16'd65535;
            cfg_reg.sensor_low_mv    <= 16'd0;
            cfg_reg.led1_cv_mode     <= 1'b0;
            cfg_reg.led2_cv_mode     <= 1'b0;
            cfg_reg.supply_lost_mv   <= 16'd12000;
            cfg_reg.supply_resume_mv <= 16'd16000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SENSOR_HIGH:   cfg_reg.sensor_high_mv   <= cfg_data;
                REG_SENSOR_LOW:    cfg_reg.sensor_low_mv    <= cfg_data;
                REG_LED1_CV:       cfg_reg.led1_cv_mode     <= cfg_data[0];
                REG_LED2_CV:       cfg_reg.led2_cv_mode     <= cfg_data[0];
                REG_SUPPLY_LOST:   cfg_reg.supply_lost_mv   <= cfg_data;
                REG_SUPPLY_RESUME: cfg_reg.supply_resume_mv <= cfg_data;
                default: ;
            endcase
        end
    end

    amon_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .op       (op)
    );

    amon_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .cfg     (cfg_reg),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_pwr_event_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18:17] == EV_PWR_LOST |-> m_tdata[16])
        else $error("supply lost word without external power on");

    a_pwr_resume_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18:17] == EV_PWR_RESUMED |-> !m_tdata[16])
        else $error("supply resumed word with external power still on");

    a_sensor_edge_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21:20] != EV_NONE |-> m_tdata[19] == (m_tdata[21:20] == EV_RISE))
        else $error("sensor edge disagrees with sensor state");

    a_invalid_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3:0] > 4'd9 |-> m_tdata[15:0] == 16'd0)
        else $error("nonzero millivolts for an unused slot");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result word appeared right after acceptance");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the ADC telemetry monitor: directed and random stream traffic against a predictor.
`timescale 1ns / 1ps

module tb;
    import amon_pkg::*;

    localparam int NUM_SLOTS        = 10;
    localparam int RAW_MAX          = (1 << ADC_BITS) - 1;
    localparam int RANDOM_PER_PHASE = 240;
    localparam int PHASES           = 5;
    localparam int HOLD_PHASE       = 2;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 16;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int PRINT_CAP        = 40;
    localparam int MAX_GAP          = 12;

    localparam logic [SLOT_W-1:0] SLOT_EXT_48V  = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_RAIL_48V = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_0_10V    = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int THERM_KNEE       = 600;
    localparam int THERM_HOT_BASE   = 4676;
    localparam int THERM_HOT_SLOPE  = 7;
    localparam int THERM_COLD_BASE  = 1649;
    localparam int THERM_COLD_SLOPE = 2;

    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic [ADC_BITS-1:0] raw;
        int unsigned         gap;
    } sample_t;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [MV_W-1:0]   mv;
        logic              ext_on;
        logic [1:0]        power_ev;
        logic              sensor_on;
        logic [1:0]        sensor_ev;
        logic [TEMP_W-1:0] temp;
        logic [MV_W-1:0]   led1_pw;
        logic [MV_W-1:0]   led2_pw;
    } telemetry_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic [S_USER_W-1:0]  s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0]  m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MV_W-1:0]      cfg_data  = '0;

    // predictor copy of the registers and monitor state
    logic [MV_W-1:0] th_sensor_high  = 16'hFFFF;
    logic [MV_W-1:0] th_sensor_low   = 16'd0;
    logic [MV_W-1:0] th_supply_lost  = 16'd12000;
    logic [MV_W-1:0] th_supply_back  = 16'd16000;
    logic            led_cv [2]      = '{1'b0, 1'b0};
    logic            ext_on_q        = 1'b0;
    logic            sensor_on_q     = 1'b0;
    logic [MV_W-1:0] led_mv [2]      = '{16'd0, 16'd0};
    logic [MV_W-1:0] led_ma [2]      = '{16'd0, 16'd0};
    logic [MV_W-1:0] led_pw [2]      = '{16'd0, 16'd0};
    logic [TEMP_W-1:0] temp_q        = '0;

    sample_t    pending_samples[$];
    telemetry_t expected_words[$];
    sample_t    next_sample;
    int         n_queued       = 0;
    int         n_accepted     = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         hold_asked     = 0;
    int         hold_served    = 0;
    int         hold_left      = 0;
    logic       s_took         = 1'b0;
    logic       m_took         = 1'b0;
    int         send_idle      = 0;

    always #6 aclk = ~aclk;

    adc_telemetry_monitor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // raw_sample[9:0], zero pad
        .s_tuser   (s_tuser),    // slot_index[3:0], zero pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // millivolts[15:0], ext_power_active[16], power_event[18:17],
                                 // sensor_active[19], sensor_edge[21:20], temperature_x10[35:22],
                                 // led1_power[51:36], led2_power[67:52], pad
        .m_tuser   (m_tuser),    // slot_echo[3:0], zero pad
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic [MV_W-1:0] scaled_mv(input logic [SLOT_W-1:0] slot,
                                                  input logic [ADC_BITS-1:0] raw);
        int unsigned num;
        int unsigned den;
        int unsigned v;
        case (slot)
            SLOT_EXT_48V, SLOT_SUPPLY, SLOT_RAIL_48V: begin num = 212; den = 12; end
            SLOT_LED1_V, SLOT_LED2_V:                 begin num = 210; den = 10; end
            SLOT_AUX:                                 begin num = 122; den = 22; end
            SLOT_LED2_I, SLOT_LED1_I:                 begin num = 30;  den = 11; end
            SLOT_0_10V:                               begin num = 542; den = 67; end
            default:                                  begin num = 1;   den = 1;  end
        endcase
        v = raw * num / den;
        v = v * 3300 / 1024;
        return (v > 65535) ? 16'hFFFF : v[MV_W-1:0];
    endfunction

    function automatic void refresh_power(input int led);
        int unsigned p;
        p = (led_mv[led] / 100) * (led_ma[led] / 100);
        led_pw[led] = (p > 65535) ? 16'hFFFF : p[MV_W-1:0];
    endfunction

    // constant-voltage mode takes the register value at the time the current arrives
    function automatic void load_current(input int led, input logic [MV_W-1:0] mv);
        int unsigned c;
        c = 32'(mv);
        if (led_cv[led])
            c = c * 5 / 2;
        led_ma[led] = (c > 65535) ? 16'hFFFF : c[MV_W-1:0];
        refresh_power(led);
    endfunction

    function automatic telemetry_t predict_word(input logic [SLOT_W-1:0] slot,
                                                input logic [ADC_BITS-1:0] raw);
        telemetry_t r;
        logic [MV_W-1:0] mv;
        int t;
        mv = '0;
        r.power_ev = EV_NONE;
        r.sensor_ev = EV_NONE;
        if (slot < NUM_SLOTS) begin
            mv = scaled_mv(slot, raw);
            case (slot)
                SLOT_LED1_V: begin
                    led_mv[0] = mv;
                    refresh_power(0);
                end
                SLOT_LED2_V: begin
                    led_mv[1] = mv;
                    refresh_power(1);
                end
                SLOT_LED1_I: load_current(0, mv);
                SLOT_LED2_I: load_current(1, mv);
                SLOT_SUPPLY: begin
                    if (mv < th_supply_lost && !ext_on_q) begin
                        ext_on_q = 1'b1;
                        r.power_ev = EV_PWR_LOST;
                    end else if (mv > th_supply_back && ext_on_q) begin
                        ext_on_q = 1'b0;
                        r.power_ev = EV_PWR_RESUMED;
                    end
                end
                SLOT_AUX: begin
                    if (mv > th_sensor_high && !sensor_on_q) begin
                        sensor_on_q = 1'b1;
                        r.sensor_ev = EV_RISE;
                    end else if (mv < th_sensor_low && sensor_on_q) begin
                        sensor_on_q = 1'b0;
                        r.sensor_ev = EV_FALL;
                    end
                end
                SLOT_THERM: begin
                    if (raw < THERM_KNEE)
                        t = THERM_HOT_BASE - THERM_HOT_SLOPE * int'(raw);
                    else
                        t = THERM_COLD_BASE - THERM_COLD_SLOPE * int'(raw);
                    temp_q = t[TEMP_W-1:0];
                end
                default: ;
            endcase
        end
        r.slot = slot;
        r.mv = mv;
        r.ext_on = ext_on_q;
        r.sensor_on = sensor_on_q;
        r.temp = temp_q;
        r.led1_pw = led_pw[0];
        r.led2_pw = led_pw[1];
        return r;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            if (mismatch_count < PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // ---------------- input side ----------------
    always @(posedge aclk) begin
        s_took <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_words.push_back(predict_word(s_tuser[SLOT_W-1:0], s_tdata[ADC_BITS-1:0]));
            n_accepted++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_idle <= 0;
        end else if (!s_tvalid || s_took) begin
            if (send_idle > 0) begin
                s_tvalid <= 1'b0;
                send_idle <= send_idle - 1;
            end else if (pending_samples.size() != 0) begin
                next_sample = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(S_DATA_W-ADC_BITS){1'b0}}, next_sample.raw};
                s_tuser <= {{(S_USER_W-SLOT_W){1'b0}}, next_sample.slot};
                send_idle <= next_sample.gap;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- output side ----------------
    always @(posedge aclk) begin : result_check
        telemetry_t want;
        m_took <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                if (mismatch_count < PRINT_CAP)
                    $display("%0t: unexpected word, expected none, actual slot %0d mv %0d",
                             $time, m_tuser[SLOT_W-1:0], m_tdata[15:0]);
                mismatch_count++;
            end else begin
                want = expected_words.pop_front();
                check_field("slot_echo", int'(want.slot), int'(m_tuser[SLOT_W-1:0]));
                check_field("millivolts", int'(want.mv), int'(m_tdata[15:0]));
                check_field("ext_power_active", int'(want.ext_on), int'(m_tdata[16]));
                check_field("power_event", int'(want.power_ev), int'(m_tdata[18:17]));
                check_field("sensor_active", int'(want.sensor_on), int'(m_tdata[19]));
                check_field("sensor_edge", int'(want.sensor_ev), int'(m_tdata[21:20]));
                check_field("temperature_x10", int'($signed(want.temp)),
                            int'($signed(m_tdata[35:22])));
                check_field("led1_power", int'(want.led1_pw), int'(m_tdata[51:36]));
                check_field("led2_power", int'(want.led2_pw), int'(m_tdata[67:52]));
            end
        end
    end

    always @(negedge aclk) begin : rx_pace
        int unsigned w;
        int rx_wait;
        bit rx_steady;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (m_took) begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            w = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            rx_wait = w;
            m_tready <= (w == 0);
        end else if (rx_wait > 1) begin
            rx_wait = rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            rx_wait = 0;
            m_tready <= 1'b1;
        end
    end

    // long receiver hold-off, counted here
    always @(negedge aclk) begin
        if (hold_served != hold_asked) begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_sample(input logic [SLOT_W-1:0] slot, input int raw,
                                input int unsigned gap);
        sample_t s;
        s.slot = slot;
        s.raw = raw[ADC_BITS-1:0];
        s.gap = gap;
        pending_samples.push_back(s);
        n_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_SENSOR_HIGH:   th_sensor_high = val;
            REG_SENSOR_LOW:    th_sensor_low = val;
            REG_LED1_CV:       led_cv[0] = val[0];
            REG_LED2_CV:       led_cv[1] = val[0];
            REG_SUPPLY_LOST:   th_supply_lost = val;
            REG_SUPPLY_RESUME: th_supply_back = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || expected_words.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // outside phase 2 the mode registers carry random upper bits; only bit 0 counts
    task automatic program_phase(input int phase);
        int hi;
        int lost;
        case (phase)
            0: begin
                // sensor and supply toggle on nearly every sample
                write_reg(REG_SENSOR_HIGH, 16'd0);
                write_reg(REG_SENSOR_LOW, 16'hFFFF);
                write_reg(REG_LED1_CV, MV_W'({$urandom_range(0, 16'h7FFF), 1'b1}));
                write_reg(REG_LED2_CV, MV_W'({$urandom_range(0, 16'h7FFF), 1'b1}));
                write_reg(REG_SUPPLY_LOST, 16'hFFFF);
                write_reg(REG_SUPPLY_RESUME, 16'd0);
            end
            1: begin
                // thresholds out of reach: state frozen
                write_reg(REG_SENSOR_HIGH, 16'hFFFF);
                write_reg(REG_SENSOR_LOW, 16'd0);
                write_reg(REG_LED1_CV, MV_W'({$urandom_range(0, 16'h7FFF), 1'b0}));
                write_reg(REG_LED2_CV, MV_W'({$urandom_range(0, 16'h7FFF), 1'b0}));
                write_reg(REG_SUPPLY_LOST, 16'd0);
                write_reg(REG_SUPPLY_RESUME, 16'hFFFF);
            end
            2: begin
                write_reg(REG_SENSOR_HIGH, 16'd9000);
                write_reg(REG_SENSOR_LOW, 16'd4000);
                write_reg(REG_LED1_CV, 16'd1);
                write_reg(REG_LED2_CV, 16'd0);
                write_reg(REG_SUPPLY_LOST, 16'd12000);
                write_reg(REG_SUPPLY_RESUME, 16'd16000);
            end
            default: begin
                hi = $urandom_range(0, 18300);
                lost = $urandom_range(0, 58000);
                write_reg(REG_SENSOR_HIGH, hi[MV_W-1:0]);
                write_reg(REG_SENSOR_LOW, MV_W'($urandom_range(0, hi)));
                write_reg(REG_LED1_CV, MV_W'($urandom_range(0, 16'hFFFF)));
                write_reg(REG_LED2_CV, MV_W'($urandom_range(0, 16'hFFFF)));
                write_reg(REG_SUPPLY_LOST, lost[MV_W-1:0]);
                write_reg(REG_SUPPLY_RESUME, MV_W'($urandom_range(lost, 58300)));
                write_reg(REG_SPARE_A, MV_W'($urandom_range(0, 16'hFFFF)));
                write_reg(REG_SPARE_B, MV_W'($urandom_range(0, 16'hFFFF)));
            end
        endcase
    endtask

    initial begin
        int slot;
        int raw;
        int unsigned gap;
        bit steady;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every slot at full scale, default registers
        for (slot = 0; slot < NUM_SLOTS; slot++)
            queue_sample(slot[SLOT_W-1:0], RAW_MAX, $urandom_range(0, MAX_GAP));
        // thermistor at both ends and around the knee
        queue_sample(SLOT_THERM, 0, $urandom_range(0, MAX_GAP));
        queue_sample(SLOT_THERM, THERM_KNEE - 1, $urandom_range(0, MAX_GAP));
        queue_sample(SLOT_THERM, THERM_KNEE, $urandom_range(0, MAX_GAP));
        // out-of-range slots leave state alone
        queue_sample(SLOT_W'(NUM_SLOTS), RAW_MAX, 0);
        queue_sample(4'hF, $urandom_range(0, RAW_MAX), 0);
        // supply lost, then resumed
        queue_sample(SLOT_SUPPLY, 0, $urandom_range(0, MAX_GAP));
        queue_sample(SLOT_SUPPLY, RAW_MAX, $urandom_range(0, MAX_GAP));
        // power recompute from voltage and from current
        queue_sample(SLOT_LED1_V, 0, 0);
        queue_sample(SLOT_LED2_I, 0, 0);
        queue_sample(SLOT_LED1_V, RAW_MAX, 0);
        queue_sample(SLOT_LED2_V, 0, 0);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            program_phase(phase);
            if (phase == HOLD_PHASE)
                hold_asked++;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (i % 40 == 0)
                    steady = ($urandom_range(0, 2) == 0);
                if (phase == HOLD_PHASE && i < 80)
                    gap = 0;
                else
                    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 11) == 0)
                    slot = $urandom_range(NUM_SLOTS, (1 << SLOT_W) - 1);
                else
                    slot = $urandom_range(0, NUM_SLOTS - 1);
                case ($urandom_range(0, 7))
                    0:       raw = 0;
                    1:       raw = RAW_MAX;
                    default: raw = $urandom_range(0, RAW_MAX);
                endcase
                queue_sample(slot[SLOT_W-1:0], raw, gap);
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
